// File: hdl/q248alu_pkg.sv
package q248alu_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W = 4;
  localparam int DEFAULT_FRACTION_BITS = 8;
  // restoring-division steps folded into one pipeline stage
  localparam int DIV_STEPS = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_GT       = 4'd4,
    CMD_LT       = 4'd5,
    CMD_GE       = 4'd6,
    CMD_LE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  // input register + operand stage + divider stages + output register
  function automatic int pipe_depth(input int fraction_bits);
    int dw;
    dw = WORD_W + fraction_bits;
    return (dw + DIV_STEPS - 1) / DIV_STEPS + 3;
  endfunction

endpackage

// File: hdl/q248alu_if.sv
interface q248alu_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [q248alu_pkg::CMD_W-1:0]  command;
  logic signed [q248alu_pkg::WORD_W-1:0] operand_a;
  logic signed [q248alu_pkg::WORD_W-1:0] operand_b;

  modport source (output valid, output command, output operand_a, output operand_b,
                  input ready);
  modport sink   (input valid, input command, input operand_a, input operand_b,
                  output ready);
endinterface

interface q248alu_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [q248alu_pkg::WORD_W-1:0] result_value;
  logic                                  compare_flag;
  logic                                  divide_error;

  modport source (output valid, output result_value, output compare_flag,
                  output divide_error, input ready);
  modport sink   (input valid, input result_value, input compare_flag,
                  input divide_error, output ready);
endinterface

// File: hdl/fixed_point_q24_8_alu_core.sv
// Channel   Dir  Handshake     Beat contents
// in_ch     in   valid/ready   command, operand_a, operand_b
// out_ch    out  valid/ready   result_value, compare_flag, divide_error
//
// One beat per cycle sustained while out_ch accepts; the depth is pipe_depth(FRACTION_BITS),
// set by the restoring divider, DIV_STEPS quotient bits per stage over WORD_W+FRACTION_BITS bits.
// All commands share the same pipeline, so results come out in order.
// rst_n (synchronous) clears the valid bits only.
// A stall on out_ch holds the output beat; upstream stages keep filling bubbles
// and in_ch.ready drops only when every stage holds a beat.
module fixed_point_q24_8_alu_core #(
  parameter int FRACTION_BITS = q248alu_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic clk,
  input  logic rst_n,
  q248alu_in_if.sink    in_ch,
  q248alu_out_if.source out_ch
);
  import q248alu_pkg::*;

  localparam int DW         = WORD_W + FRACTION_BITS;  // dividend / quotient width
  localparam int RW         = WORD_W + 1;              // partial remainder width
  localparam int DIV_STAGES = (DW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DEPTH      = pipe_depth(FRACTION_BITS);

  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] res;
    logic              flag;
    logic              err;
    logic              neg;
    logic [RW-1:0]     rem;
    logic [DW-1:0]     quo;
    logic [WORD_W-1:0] dvsr;
  } stage_t;

  // vld_r[0] is the input register, vld_r[i+1] goes with st_r[i]
  logic [DEPTH-1:0]          vld_r;
  logic [DEPTH-1:0]          vld_nxt;
  logic [DEPTH-1:0]          move;
  logic [CMD_W-1:0]          in_cmd_r;
  logic signed [WORD_W-1:0]  in_a_r;
  logic signed [WORD_W-1:0]  in_b_r;
  logic signed [2*WORD_W-1:0] prod_r;
  stage_t                    st_r   [DEPTH-1];
  stage_t                    st_nxt [DEPTH-1];

  // a stage advances when it is empty or the one after it advances
  always_comb begin
    move[DEPTH-1] = !vld_r[DEPTH-1] || out_ch.ready;
    for (int k = DEPTH - 2; k >= 0; k--) begin
      move[k] = !vld_r[k] || move[k+1];
    end
  end

  assign in_ch.ready = move[0];

  always_comb begin
    vld_nxt[0] = move[0] ? in_ch.valid : vld_r[0];
    for (int k = 1; k < DEPTH; k++) begin
      vld_nxt[k] = move[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  // operand stage: everything but mul and div finishes here
  always_comb begin
    logic [WORD_W-1:0] abs_a;
    logic [WORD_W-1:0] abs_b;
    stage_t s;
    abs_a = in_a_r[WORD_W-1] ? WORD_W'(-in_a_r) : in_a_r;
    abs_b = in_b_r[WORD_W-1] ? WORD_W'(-in_b_r) : in_b_r;
    s      = '0;
    s.cmd  = cmd_t'(in_cmd_r);
    s.neg  = in_a_r[WORD_W-1] ^ in_b_r[WORD_W-1];
    s.rem  = '0;
    s.quo  = {abs_a, {FRACTION_BITS{1'b0}}};
    s.dvsr = abs_b;
    case (s.cmd)
      CMD_ADD:      s.res = in_a_r + in_b_r;
      CMD_SUB:      s.res = in_a_r - in_b_r;
      CMD_MUL:      s.res = '0;
      CMD_DIV:      s.err = (in_b_r == '0);
      CMD_GT:       s.flag = (in_a_r > in_b_r);
      CMD_LT:       s.flag = (in_a_r < in_b_r);
      CMD_GE:       s.flag = (in_a_r >= in_b_r);
      CMD_LE:       s.flag = (in_a_r <= in_b_r);
      CMD_EQ:       s.flag = (in_a_r == in_b_r);
      CMD_NE:       s.flag = (in_a_r != in_b_r);
      CMD_MIN:      s.res = (in_a_r < in_b_r) ? in_a_r : in_b_r;
      CMD_MAX:      s.res = (in_a_r > in_b_r) ? in_a_r : in_b_r;
      CMD_INC:      s.res = in_a_r + WORD_W'(1);
      CMD_DEC:      s.res = in_a_r - WORD_W'(1);
      CMD_FROM_INT: s.res = in_a_r << FRACTION_BITS;
      CMD_TO_INT:   s.res = in_a_r >>> FRACTION_BITS;
      default:      s.res = '0;
    endcase
    st_nxt[0] = s;
  end

  // divider stages, DIV_STEPS restoring steps each; the quotient shifts into quo
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    always_comb begin
      logic [RW-1:0] trial;
      logic          q_bit;
      stage_t        s;
      trial = '0;
      q_bit = 1'b0;
      s = st_r[g];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (g * DIV_STEPS + j < DW) begin
          trial = {s.rem[RW-2:0], s.quo[DW-1]};
          q_bit = (trial >= {1'b0, s.dvsr});
          s.rem = q_bit ? trial - {1'b0, s.dvsr} : trial;
          s.quo = {s.quo[DW-2:0], q_bit};
        end
      end
      // product registered one stage back, take its fixed-point slice here
      if (g == 0 && s.cmd == CMD_MUL) begin
        s.res = prod_r[FRACTION_BITS +: WORD_W];
      end
      st_nxt[g+1] = s;
    end
  end

  // output stage: sign the quotient, zero it on divide by zero
  always_comb begin
    stage_t s;
    s = st_r[DIV_STAGES];
    if (s.cmd == CMD_DIV) begin
      if (s.err) begin
        s.res = '0;
      end else if (s.neg) begin
        s.res = -s.quo[WORD_W-1:0];
      end else begin
        s.res = s.quo[WORD_W-1:0];
      end
    end
    st_nxt[DEPTH-2] = s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move[0]) begin
      in_cmd_r <= in_ch.command;
      in_a_r   <= in_ch.operand_a;
      in_b_r   <= in_ch.operand_b;
    end
    if (move[1]) begin
      prod_r <= in_a_r * in_b_r;
    end
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (move[i+1]) begin
        st_r[i] <= st_nxt[i];
      end
    end
  end

  assign out_ch.valid        = vld_r[DEPTH-1];
  assign out_ch.result_value = st_r[DEPTH-2].res;
  assign out_ch.compare_flag = st_r[DEPTH-2].flag;
  assign out_ch.divide_error = st_r[DEPTH-2].err;

endmodule

// File: hdl/q248alu_chk.sv
module q248alu_chk #(
  parameter int FRACTION_BITS = q248alu_pkg::DEFAULT_FRACTION_BITS
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic signed [q248alu_pkg::WORD_W-1:0] out_result_value,
  input logic                                  out_compare_flag,
  input logic                                  out_divide_error
);
  import q248alu_pkg::*;

  localparam int DEPTH = pipe_depth(FRACTION_BITS);
  localparam int CW    = $clog2(DEPTH + 1) + 1;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_valid && in_ready) begin
      cnt_nxt = cnt_nxt + CW'(1);
    end
    if (out_valid && out_ready) begin
      cnt_nxt = cnt_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value)
      && $stable(out_compare_flag) && $stable(out_divide_error))
    else $error("output beat changed while stalled");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("more beats in flight than pipeline stages");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result beat without a pending input beat");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready || !out_valid |-> in_ready)
    else $error("input stalled while output path is free");

  a_fields_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_compare_flag || out_divide_error) |->
      out_result_value == '0 && !(out_compare_flag && out_divide_error))
    else $error("flag beat with nonzero result");

endmodule

bind fixed_point_q24_8_alu_core q248alu_chk #(
  .FRACTION_BITS(FRACTION_BITS)
) u_q248alu_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_compare_flag (out_ch.compare_flag),
  .out_divide_error (out_ch.divide_error)
);

// File: sim/alu_result_checker.sv
module alu_result_checker #(
  parameter int FRACTION_BITS = q248alu_pkg::DEFAULT_FRACTION_BITS
) (
  input  logic   clk,
  input  logic   rst_n,
  q248alu_in_if  in_ch,
  q248alu_out_if out_ch,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import q248alu_pkg::*;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     flag;
    logic                     err;
  } alu_result_t;

  alu_result_t predicted_results[$];

  function automatic alu_result_t alu_predict(input cmd_t op,
                                              input logic signed [WORD_W-1:0] a,
                                              input logic signed [WORD_W-1:0] b);
    alu_result_t r;
    logic signed [63:0] wa;
    logic signed [63:0] wb;
    logic signed [63:0] wide;
    wa = a;
    wb = b;
    r = '0;
    case (op)
      CMD_ADD: r.value = a + b;
      CMD_SUB: r.value = a - b;
      CMD_MUL: begin
        wide = (wa * wb) >>> FRACTION_BITS;
        r.value = wide[WORD_W-1:0];
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.err = 1'b1;
        end else begin
          // 64-bit dividend, truncating divide, keep the low word
          wide = (wa <<< FRACTION_BITS) / wb;
          r.value = wide[WORD_W-1:0];
        end
      end
      CMD_GT: r.flag = (a > b);
      CMD_LT: r.flag = (a < b);
      CMD_GE: r.flag = (a >= b);
      CMD_LE: r.flag = (a <= b);
      CMD_EQ: r.flag = (a == b);
      CMD_NE: r.flag = (a != b);
      CMD_MIN: r.value = (a < b) ? a : b;
      CMD_MAX: r.value = (a > b) ? a : b;
      CMD_INC: r.value = a + 1;
      CMD_DEC: r.value = a - 1;
      CMD_FROM_INT: r.value = a <<< FRACTION_BITS;
      default: r.value = a >>> FRACTION_BITS;
    endcase
    return r;
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin : monitor
    alu_result_t want;
    alu_result_t got;
    int miss;
    miss = 0;
    if (rst_n) begin
      // retire the output beat first so a same-cycle input cannot cover it
      if (out_ch.valid && out_ch.ready) begin
        got.value = out_ch.result_value;
        got.flag = out_ch.compare_flag;
        got.err = out_ch.divide_error;
        if (predicted_results.size() == 0) begin
          $display("%0t: unexpected result beat value %0d flag %b err %b",
                   $time, got.value, got.flag, got.err);
          miss++;
        end else begin
          want = predicted_results.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $time, want.value, got.value);
            miss++;
          end
          if (got.flag !== want.flag) begin
            $display("%0t: compare_flag expected %b actual %b", $time, want.flag, got.flag);
            miss++;
          end
          if (got.err !== want.err) begin
            $display("%0t: divide_error expected %b actual %b", $time, want.err, got.err);
            miss++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predicted_results.push_back(alu_predict(cmd_t'(in_ch.command),
                                                in_ch.operand_a, in_ch.operand_b));
    end
    fail_count <= fail_count + miss;
    pending <= predicted_results.size();
  end

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import q248alu_pkg::*;

  localparam int FRACTION_BITS = DEFAULT_FRACTION_BITS;
  localparam int RANDOM_ITEMS = 1800;
  localparam int DRAIN_CYCLES = pipe_depth(FRACTION_BITS) + 4;
  localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   burst = 1'b0;

  always #2 clk = ~clk;

  q248alu_in_if  in_ch();
  q248alu_out_if out_ch();

  fixed_point_q24_8_alu_core #(.FRACTION_BITS(FRACTION_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  alu_result_checker #(.FRACTION_BITS(FRACTION_BITS)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [WORD_W-1:0] rand_operand();
    logic signed [WORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 4096) - 2048;
      1: begin
        case ($urandom_range(0, 6))
          0: v = W_MAX;
          1: v = W_MIN;
          2: v = 0;
          3: v = 1;
          4: v = -1;
          5: v = 1 <<< FRACTION_BITS;
          default: v = -(1 <<< FRACTION_BITS);
        endcase
      end
      2: v = $signed($urandom) >>> $urandom_range(8, 30);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic put_item(input cmd_t op, input logic signed [WORD_W-1:0] a,
                          input logic signed [WORD_W-1:0] b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.command <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : sink_pacing
    int run;
    int stall;
    out_ch.ready <= 1'b0;
    repeat (6) @(posedge clk);
    forever begin
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    cmd_t op;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    int r;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_ADD;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // overflow and wrap
    put_item(CMD_ADD, W_MAX, 1);
    put_item(CMD_ADD, W_MIN, W_MIN);
    put_item(CMD_SUB, W_MIN, 1);
    put_item(CMD_SUB, 0, W_MIN);
    put_item(CMD_MUL, W_MAX, W_MAX);
    put_item(CMD_MUL, W_MIN, W_MIN);
    put_item(CMD_MUL, -1, 1);
    put_item(CMD_MUL, 32'sh180, -(1 <<< FRACTION_BITS));
    // divide by zero, wrapping quotient, truncation toward zero
    put_item(CMD_DIV, 5, 0);
    put_item(CMD_DIV, W_MIN, -1);
    put_item(CMD_DIV, -256, 768);
    put_item(CMD_DIV, W_MAX, 1);
    // comparisons, ties included
    put_item(CMD_GT, 1, 1);
    put_item(CMD_LT, W_MIN, W_MAX);
    put_item(CMD_GE, -1, -1);
    put_item(CMD_LE, W_MAX, W_MIN);
    put_item(CMD_EQ, W_MIN, W_MIN);
    put_item(CMD_NE, 0, 1);
    // min/max ties return operand_b
    put_item(CMD_MIN, 7, 7);
    put_item(CMD_MAX, -3, -3);
    put_item(CMD_MIN, W_MIN, W_MAX);
    put_item(CMD_MAX, W_MIN, W_MAX);
    // unary commands, operand_b is don't-care
    put_item(CMD_INC, W_MAX, $urandom);
    put_item(CMD_DEC, W_MIN, $urandom);
    put_item(CMD_FROM_INT, W_MAX, $urandom);
    put_item(CMD_TO_INT, -1, $urandom);
    put_item(CMD_TO_INT, W_MIN, $urandom);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0)
        burst = ($urandom_range(0, 3) == 0);
      op = cmd_t'($urandom_range(0, 15));
      a = rand_operand();
      b = rand_operand();
      r = $urandom_range(0, 9);
      if (r == 0)
        b = a;
      else if (r == 1 && op == CMD_DIV)
        b = 0;
      put_item(op, a, b);
    end
    in_ch.valid <= 1'b0;

    // let the last beat show up in pending before polling it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin : watchdog
    #(3_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
